@@ design/npco_pkg.sv @@
package npco_pkg;

  localparam int COORD_BITS    = 12;
  localparam int ID_BITS       = 16;
  localparam int DIST_BITS     = 2 * COORD_BITS + 1;
  localparam int SQ_BITS       = 2 * COORD_BITS;
  localparam int TAN_BITS      = 32;
  localparam int PROD_BITS     = TAN_BITS + COORD_BITS;
  localparam int CFG_ADDR_BITS = 1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  // floor(tan(22.5 deg) * 2^32)
  localparam logic [TAN_BITS-1:0] TAN_22_5_Q32 = 32'h6A09E667;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_REF_X = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_REF_Y = 1'b1;

  typedef enum logic [2:0] {
    OCT_E,
    OCT_NE,
    OCT_N,
    OCT_NW,
    OCT_W,
    OCT_SW,
    OCT_S,
    OCT_SE
  } octant_t;

  // One classified candidate, as handed from the front end to the scan.
  typedef struct packed {
    logic                 nonzero;
    logic                 last;
    logic [ID_BITS-1:0]   id;
    logic [DIST_BITS-1:0] sq_dist;
    octant_t              oct;
  } cand_t;

endpackage

@@ design/nearest_point_compass_octant.sv @@
// Nearest-point scan with compass octant. Each input word carries one
// candidate point (column, row, id) and a tlast flag closing the scan; the
// block keeps the candidate with the smallest squared distance to the
// reference set through the configuration port (earliest wins on a tie,
// points on the reference itself are ignored) and, on the closing word,
// sends one result word: found in tuser, and the winner's id, squared
// distance and octant (0 east, counting counterclockwise to 7 southeast,
// with rows growing downward) in tdata. The block takes one word per clock
// cycle while a queue slot is free for it; a result word passes through two
// front-end stages (offsets, then squares and tangent products), the
// four-entry queue and the output register. Write the reference only while
// no scan is in flight.
module nearest_point_compass_octant (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_we,
  input  logic [npco_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [npco_pkg::COORD_BITS-1:0]     cfg_data,

  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: point_x[11:0], point_y[23:12], point_id[39:24].
  input  logic [39:0]                         s_axis_tdata,
  input  logic                                s_axis_tlast,

  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: nearest_id[15:0], dist_sq[40:16], octant[43:41],
  // zero fill [47:44].
  output logic [47:0]                         m_axis_tdata,
  // Fields from bit 0: found[0].
  output logic                                m_axis_tuser
);

  logic [npco_pkg::COORD_BITS-1:0]     ref_x;
  logic [npco_pkg::COORD_BITS-1:0]     ref_y;

  logic                                push;
  npco_pkg::cand_t                     push_entry;
  logic                                pop;
  logic                                q_valid;
  npco_pkg::cand_t                     q_head;
  logic [npco_pkg::QPTR_BITS:0]        q_count;

  logic [npco_pkg::ID_BITS-1:0]        out_id;
  logic [npco_pkg::DIST_BITS-1:0]      out_dist;
  npco_pkg::octant_t                   out_oct;

  // Reference position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        npco_pkg::CFG_REF_X: ref_x <= cfg_data;
        npco_pkg::CFG_REF_Y: ref_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end computes distance and octant for every candidate.
  npco_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .point_x     (s_axis_tdata[11:0]),
    .point_y     (s_axis_tdata[23:12]),
    .point_id    (s_axis_tdata[39:24]),
    .last_point  (s_axis_tlast),
    .ref_x       (ref_x),
    .ref_y       (ref_y),
    .queue_count (q_count),
    .push        (push),
    .push_entry  (push_entry)
  );

  npco_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (q_head),
    .count      (q_count)
  );

  // The back end keeps the running minimum and emits the result.
  npco_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_found (m_axis_tuser),
    .out_id    (out_id),
    .out_dist  (out_dist),
    .out_oct   (out_oct)
  );

  assign m_axis_tdata = {4'b0000, out_oct, out_dist, out_id};

endmodule

@@ design/npco_front.sv @@
module npco_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [npco_pkg::COORD_BITS-1:0]       point_x,
  input  logic [npco_pkg::COORD_BITS-1:0]       point_y,
  input  logic [npco_pkg::ID_BITS-1:0]          point_id,
  input  logic                                  last_point,
  input  logic [npco_pkg::COORD_BITS-1:0]       ref_x,
  input  logic [npco_pkg::COORD_BITS-1:0]       ref_y,
  input  logic [npco_pkg::QPTR_BITS:0]          queue_count,
  output logic                                  push,
  output npco_pkg::cand_t                       push_entry
);

  localparam int CB = npco_pkg::COORD_BITS;

  logic                            accept;
  logic [CB:0]                     dx;
  logic [CB:0]                     dy;
  logic [CB:0]                     dx_mag;
  logic [CB:0]                     dy_mag;
  logic [npco_pkg::QPTR_BITS+1:0]  pending;

  // Stage 1: offsets as magnitude and sign.
  logic                            v1;
  logic [CB-1:0]                   a1;
  logic [CB-1:0]                   b1;
  logic                            xpos1;
  logic                            yneg1;
  logic                            nz1;
  logic                            last1;
  logic [npco_pkg::ID_BITS-1:0]    id1;

  // Stage 2: squares and tangent products.
  logic                            v2;
  logic [CB-1:0]                   a2;
  logic [CB-1:0]                   b2;
  logic [npco_pkg::SQ_BITS-1:0]    sqa2;
  logic [npco_pkg::SQ_BITS-1:0]    sqb2;
  logic [npco_pkg::PROD_BITS-1:0]  ta2;
  logic [npco_pkg::PROD_BITS-1:0]  tb2;
  logic                            xpos2;
  logic                            yneg2;
  logic                            nz2;
  logic                            last2;
  logic [npco_pkg::ID_BITS-1:0]    id2;

  logic                            east_west;
  logic                            north_south;
  npco_pkg::octant_t               oct;

  // Words still in the stages all have a queue slot reserved.
  assign pending  = {1'b0, queue_count} + {{(npco_pkg::QPTR_BITS+1){1'b0}}, v1}
                  + {{(npco_pkg::QPTR_BITS+1){1'b0}}, v2};
  assign in_ready = pending < (npco_pkg::QPTR_BITS+2)'(npco_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  assign dx     = {1'b0, point_x} - {1'b0, ref_x};
  assign dy     = {1'b0, point_y} - {1'b0, ref_y};
  assign dx_mag = dx[CB] ? -dx : dx;
  assign dy_mag = dy[CB] ? -dy : dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a1    <= dx_mag[CB-1:0];
    b1    <= dy_mag[CB-1:0];
    xpos1 <= !dx[CB] && (dx != '0);
    yneg1 <= dy[CB];
    nz1   <= (dx != '0) || (dy != '0);
    last1 <= last_point;
    id1   <= point_id;

    a2    <= a1;
    b2    <= b1;
    sqa2  <= {{CB{1'b0}}, a1} * {{CB{1'b0}}, a1};
    sqb2  <= {{CB{1'b0}}, b1} * {{CB{1'b0}}, b1};
    ta2   <= {{CB{1'b0}}, npco_pkg::TAN_22_5_Q32} * {{npco_pkg::TAN_BITS{1'b0}}, a1};
    tb2   <= {{CB{1'b0}}, npco_pkg::TAN_22_5_Q32} * {{npco_pkg::TAN_BITS{1'b0}}, b1};
    xpos2 <= xpos1;
    yneg2 <= yneg1;
    nz2   <= nz1;
    last2 <= last1;
    id2   <= id1;
  end

  assign east_west   = {b2, {npco_pkg::TAN_BITS{1'b0}}} < ta2;
  assign north_south = {a2, {npco_pkg::TAN_BITS{1'b0}}} < tb2;

  always_comb begin
    if (east_west) begin
      oct = xpos2 ? npco_pkg::OCT_E : npco_pkg::OCT_W;
    end else if (north_south) begin
      oct = yneg2 ? npco_pkg::OCT_N : npco_pkg::OCT_S;
    end else if (xpos2) begin
      oct = yneg2 ? npco_pkg::OCT_NE : npco_pkg::OCT_SE;
    end else begin
      oct = yneg2 ? npco_pkg::OCT_NW : npco_pkg::OCT_SW;
    end
  end

  assign push               = v2;
  assign push_entry.nonzero = nz2;
  assign push_entry.last    = last2;
  assign push_entry.id      = id2;
  assign push_entry.sq_dist = {1'b0, sqa2} + {1'b0, sqb2};
  assign push_entry.oct     = oct;

endmodule

@@ design/npco_queue.sv @@
module npco_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  npco_pkg::cand_t               push_entry,
  input  logic                          pop,
  output logic                          not_empty,
  output npco_pkg::cand_t               head,
  output logic [npco_pkg::QPTR_BITS:0]  count
);

  npco_pkg::cand_t                 slots [npco_pkg::QUEUE_DEPTH];
  logic [npco_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [npco_pkg::QPTR_BITS-1:0]  rd_ptr;

  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ design/npco_back.sv @@
module npco_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  npco_pkg::cand_t                    q_head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [npco_pkg::ID_BITS-1:0]       out_id,
  output logic [npco_pkg::DIST_BITS-1:0]     out_dist,
  output npco_pkg::octant_t                  out_oct
);

  logic                              have_best;
  logic [npco_pkg::DIST_BITS-1:0]    best_dist;
  logic [npco_pkg::ID_BITS-1:0]      best_id;
  npco_pkg::octant_t                 best_oct;

  logic                              better;
  logic                              have_best_next;
  logic [npco_pkg::DIST_BITS-1:0]    best_dist_next;
  logic [npco_pkg::ID_BITS-1:0]      best_id_next;
  npco_pkg::octant_t                 best_oct_next;

  // A closing word needs the output register; others only need the queue.
  assign pop    = q_valid && (!q_head.last || !out_valid || out_ready);
  assign better = q_head.nonzero && (!have_best || (q_head.sq_dist < best_dist));

  always_comb begin
    have_best_next = have_best;
    best_dist_next = best_dist;
    best_id_next   = best_id;
    best_oct_next  = best_oct;
    if (better) begin
      have_best_next = 1'b1;
      best_dist_next = q_head.sq_dist;
      best_id_next   = q_head.id;
      best_oct_next  = q_head.oct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_dist <= '0;
      best_id   <= '0;
      best_oct  <= npco_pkg::OCT_E;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (q_head.last) begin
          have_best <= 1'b0;
          best_dist <= '0;
          best_id   <= '0;
          best_oct  <= npco_pkg::OCT_E;
        end else begin
          have_best <= have_best_next;
          best_dist <= best_dist_next;
          best_id   <= best_id_next;
          best_oct  <= best_oct_next;
        end
      end
      if (pop && q_head.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // With nothing found the running values are still at zero.
  always_ff @(posedge clk) begin
    if (pop && q_head.last) begin
      out_found <= have_best_next;
      out_id    <= best_id_next;
      out_dist  <= best_dist_next;
      out_oct   <= best_oct_next;
    end
  end

endmodule

@@ verif/nearest_point_compass_octant_tb.sv @@
module nearest_point_compass_octant_tb;
  import npco_pkg::*;

  // One result word as the scan reports it.
  typedef struct packed {
    logic                 found;
    logic [ID_BITS-1:0]   id;
    logic [DIST_BITS-1:0] sq_dist;
    octant_t              oct;
  } scan_result_t;

  // One row of the directed table. The observer position travels with each
  // row, and the bench moves the observer (after letting the block drain)
  // whenever it changes. When typed is set, the result that the row closes
  // is taken from the row itself rather than from the tracker below.
  typedef struct packed {
    logic [COORD_BITS-1:0] obs_x;
    logic [COORD_BITS-1:0] obs_y;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [ID_BITS-1:0]    id;
    logic                  last;
    logic                  typed;
    scan_result_t          want;
  } point_row_t;

  // How busy a side of the stream is: no idling, short frequent pauses, or
  // long pauses.
  typedef enum int {
    PACE_FULL,
    PACE_CHOPPY,
    PACE_SLOW
  } pace_t;

  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 9;
  localparam int RANDOM_ITEMS   = 1625;
  localparam int DIRECTED_ROWS  = 24;
  localparam int OBS_CORNER_X [5] = '{0, 4095, 0, 4095, 2048};
  localparam int OBS_CORNER_Y [5] = '{0, 4095, 4095, 0, 2048};

  localparam scan_result_t UNTYPED = '0;

  // The first rows use the observer at its reset position (0, 0), so only
  // east, south and southeast can occur there; the rest put the observer in
  // the middle of the grid and walk all eight octants, the tie rule inside the
  // east and north sectors, the east/southeast border, and the farthest corner.
  point_row_t directed_rows [DIRECTED_ROWS] = '{
    // A scan holding only the reference point finds nothing.
    '{12'd0, 12'd0, 12'd0, 12'd0, 16'h1111, 1'b1, 1'b1, '{1'b0, 16'h0000, 25'd0, OCT_E}},
    // Far corner: the largest squared distance, on the diagonal.
    '{12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF, 1'b1, 1'b1,
      '{1'b1, 16'hFFFF, 25'd33538050, OCT_SE}},
    '{12'd0, 12'd0, 12'd4095, 12'd0, 16'h0001, 1'b1, 1'b1,
      '{1'b1, 16'h0001, 25'd16769025, OCT_E}},
    '{12'd0, 12'd0, 12'd0, 12'd4095, 16'h0002, 1'b1, 1'b1,
      '{1'b1, 16'h0002, 25'd16769025, OCT_S}},
    // Two candidates at distance one: the earlier one wins.
    '{12'd0, 12'd0, 12'd1, 12'd0, 16'h0003, 1'b0, 1'b0, UNTYPED},
    '{12'd0, 12'd0, 12'd0, 12'd1, 16'h0004, 1'b1, 1'b1, '{1'b1, 16'h0003, 25'd1, OCT_E}},
    // A longer scan made only of reference points still finds nothing.
    '{12'd0, 12'd0, 12'd0, 12'd0, 16'h0005, 1'b0, 1'b0, UNTYPED},
    '{12'd0, 12'd0, 12'd0, 12'd0, 16'h0006, 1'b1, 1'b1, '{1'b0, 16'h0000, 25'd0, OCT_E}},
    // Reference points mixed with a tie, closed by a reference point.
    '{12'd0, 12'd0, 12'd0, 12'd0, 16'h0007, 1'b0, 1'b0, UNTYPED},
    '{12'd0, 12'd0, 12'd3, 12'd4, 16'h0008, 1'b0, 1'b0, UNTYPED},
    '{12'd0, 12'd0, 12'd4, 12'd3, 16'h0009, 1'b0, 1'b0, UNTYPED},
    '{12'd0, 12'd0, 12'd0, 12'd0, 16'h000A, 1'b1, 1'b0, UNTYPED},
    // Observer in the middle: one single-point scan per octant.
    '{12'd2048, 12'd2048, 12'd2148, 12'd2048, 16'h0100, 1'b1, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd2148, 12'd1948, 16'h0101, 1'b1, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd2048, 12'd1948, 16'h0102, 1'b1, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd1948, 12'd1948, 16'h0103, 1'b1, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd1948, 12'd2048, 16'h0104, 1'b1, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd1948, 12'd2148, 16'h0105, 1'b1, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd2048, 12'd2148, 16'h0106, 1'b1, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd2148, 12'd2148, 16'h0107, 1'b1, 1'b0, UNTYPED},
    // Offsets (100, 41) and (41, -100) sit just inside the east and north
    // sectors and have equal distances, so the first one must win.
    '{12'd2048, 12'd2048, 12'd2148, 12'd2089, 16'h0108, 1'b0, 1'b0, UNTYPED},
    '{12'd2048, 12'd2048, 12'd2089, 12'd1948, 16'h0109, 1'b1, 1'b0, UNTYPED},
    // Offset (100, 42) falls just across the border into the diagonal.
    '{12'd2048, 12'd2048, 12'd2148, 12'd2090, 16'h010A, 1'b1, 1'b0, UNTYPED},
    // The grid origin seen from the middle: largest negative offsets.
    '{12'd2048, 12'd2048, 12'd0, 12'd0, 16'h8000, 1'b1, 1'b0, UNTYPED}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0]     cfg_addr = CFG_REF_X;
  logic [COORD_BITS-1:0]        cfg_data = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [39:0]                  s_axis_tdata = '0;
  logic                         s_axis_tlast = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [47:0]                  m_axis_tdata;
  logic                         m_axis_tuser;

  // Results still owed by the block, oldest first.
  scan_result_t pending_results [$];
  scan_result_t oldest_result;
  int unsigned  mismatches = 0;

  // The tracker's own copy of the observer position and of the running
  // nearest candidate.
  logic [COORD_BITS-1:0] obs_ref_x = '0;
  logic [COORD_BITS-1:0] obs_ref_y = '0;
  logic                  have_best = 1'b0;
  logic [DIST_BITS-1:0]  best_dist = '0;
  logic [ID_BITS-1:0]    best_id = '0;
  int                    best_dx = 0;
  int                    best_dy = 0;

  // Pacing of both sides, set per phase by the stimulus process.
  pace_t       send_pace = PACE_CHOPPY;
  pace_t       take_pace = PACE_CHOPPY;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;

  nearest_point_compass_octant dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Octant from exact integer comparisons: the offset is called east or west
  // when |dy| is below tan(22.5 deg) * |dx|, north or south when |dx| is below
  // tan(22.5 deg) * |dy|, and diagonal otherwise. Rows grow downward, so a
  // negative dy points north.
  function automatic octant_t compass_octant(input int dx, input int dy);
    longint unsigned mag_x;
    longint unsigned mag_y;
    mag_x = (dx < 0) ? -dx : dx;
    mag_y = (dy < 0) ? -dy : dy;
    if ((mag_y << 32) < TAN_22_5_Q32 * mag_x) begin
      return (dx > 0) ? OCT_E : OCT_W;
    end
    if ((mag_x << 32) < TAN_22_5_Q32 * mag_y) begin
      return (dy < 0) ? OCT_N : OCT_S;
    end
    if (dx > 0) begin
      return (dy < 0) ? OCT_NE : OCT_SE;
    end
    return (dy < 0) ? OCT_NW : OCT_SW;
  endfunction

  // Folds one accepted candidate into the running nearest point. A closing
  // candidate is folded in first; then the result is formed and the scan
  // starts over, while the observer position stays.
  task automatic track_nearest(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                               input logic [ID_BITS-1:0] id, input logic last,
                               output scan_result_t res);
    int          dx;
    int          dy;
    int unsigned cand_dist;
    dx = int'(x) - int'(obs_ref_x);
    dy = int'(y) - int'(obs_ref_y);
    res = '0;
    if (dx != 0 || dy != 0) begin
      cand_dist = dx * dx + dy * dy;
      if (!have_best || cand_dist < best_dist) begin
        have_best = 1'b1;
        best_dist = cand_dist[DIST_BITS-1:0];
        best_id   = id;
        best_dx   = dx;
        best_dy   = dy;
      end
    end
    if (last) begin
      if (have_best) begin
        res = '{1'b1, best_id, best_dist, compass_octant(best_dx, best_dy)};
      end
      have_best = 1'b0;
      best_dist = '0;
      best_id   = '0;
      best_dx   = 0;
      best_dy   = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one candidate word and returns at the edge where it is taken.
  // Words go out in bursts; between bursts valid drops for a while, as the
  // current send pace says. Valid only ever changes in a step where it is
  // assigned once, so a word that follows straight on keeps valid high.
  task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [ID_BITS-1:0] id, input logic last,
                            input logic typed, input scan_result_t want);
    scan_result_t predicted;
    int unsigned  gap;
    if (burst_left == 0) begin
      case (send_pace)
        PACE_CHOPPY: begin
          gap = $urandom_range(1, 3);
          burst_left = $urandom_range(1, 4);
        end
        PACE_SLOW: begin
          gap = $urandom_range(1, 12);
          burst_left = $urandom_range(5, 30);
        end
        default: begin
          gap = 0;
          burst_left = 1000;
        end
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {id, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    track_nearest(x, y, id, last, predicted);
    if (last) begin
      pending_results.push_back(typed ? want : predicted);
    end
  endtask

  // Waits until every owed result has come out, then lets the block settle so
  // that nothing is left in the front end or the queue.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Moves the observer. Every scan before this ends with a closing word, so
  // once the block is idle both registers can be written back to back.
  task automatic move_observer(input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_REF_X;
    cfg_data <= x;
    @(posedge clk);
    cfg_addr <= CFG_REF_Y;
    cfg_data <= y;
    @(posedge clk);
    cfg_we    <= 1'b0;
    obs_ref_x = x;
    obs_ref_y = y;
    burst_left = 0;
  endtask

  // Result side: tready follows a stall pattern of its own. Choppy pacing
  // drops it now and then, slow pacing holds it low for
  // long stretches, and full pacing never drops it.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      case (take_pace)
        PACE_CHOPPY: begin
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
        end
        PACE_SLOW: begin
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(4, 20);
        end
        default: ;
      endcase
    end
  end

  // Every result word taken is checked field by field against the oldest
  // owed result. The fill bits above the octant must read zero.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none owed, tdata", m_axis_tdata, 0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tuser !== oldest_result.found) begin
          report_mismatch("found", m_axis_tuser, oldest_result.found);
        end
        if (m_axis_tdata[15:0] !== oldest_result.id) begin
          report_mismatch("nearest_id", m_axis_tdata[15:0], oldest_result.id);
        end
        if (m_axis_tdata[40:16] !== oldest_result.sq_dist) begin
          report_mismatch("dist_sq", m_axis_tdata[40:16], oldest_result.sq_dist);
        end
        if (m_axis_tdata[43:41] !== oldest_result.oct) begin
          report_mismatch("octant", m_axis_tdata[43:41], oldest_result.oct);
        end
        if (m_axis_tdata[47:44] !== 4'b0000) begin
          report_mismatch("zero fill", m_axis_tdata[47:44], 0);
        end
      end
    end
  end

  initial begin
    int unsigned           scan_len;
    int unsigned           sent;
    int unsigned           pick;
    int                    dx;
    int                    dy;
    logic                  only_ref;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic [COORD_BITS-1:0] next_x;
    logic [COORD_BITS-1:0] next_y;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed table, with both sides pausing now and then.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].obs_x != obs_ref_x || directed_rows[r].obs_y != obs_ref_y) begin
        move_observer(directed_rows[r].obs_x, directed_rows[r].obs_y);
      end
      send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].id,
                 directed_rows[r].last, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases: the observer at each corner, the middle, then random
    // spots, and every pairing of sender and receiver pacing, the first
    // phase without any idling at all. Scans are mostly short, with points
    // clustered around the observer so that ties, octant borders and
    // replacements of the running best happen often; some points land on
    // the observer itself, at the grid edges or anywhere on the grid.
    prev_x = '0;
    prev_y = '0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 5) begin
        next_x = COORD_BITS'(OBS_CORNER_X[phase]);
        next_y = COORD_BITS'(OBS_CORNER_Y[phase]);
      end else begin
        next_x = COORD_BITS'($urandom_range(0, 4095));
        next_y = COORD_BITS'($urandom_range(0, 4095));
      end
      move_observer(next_x, next_y);
      send_pace = pace_t'(phase % 3);
      take_pace = pace_t'((phase / 3) % 3);
      sent = 0;
      while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
        scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        only_ref = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < scan_len; k++) begin
          pick = $urandom_range(0, 99);
          if (only_ref || pick < 8) begin
            px = obs_ref_x;
            py = obs_ref_y;
          end else if (pick < 50) begin
            dx = int'($urandom_range(0, 16)) - 8;
            dy = int'($urandom_range(0, 16)) - 8;
            px = obs_ref_x + 12'(dx);
            py = obs_ref_y + 12'(dy);
          end else if (pick < 65) begin
            dx = int'($urandom_range(0, 600)) - 300;
            dy = int'($urandom_range(0, 600)) - 300;
            px = obs_ref_x + 12'(dx);
            py = obs_ref_y + 12'(dy);
          end else if (pick < 75 && k != 0) begin
            // Same spot again under another id: a tie with the previous one.
            px = prev_x;
            py = prev_y;
          end else if (pick < 92) begin
            px = COORD_BITS'($urandom_range(0, 4095));
            py = COORD_BITS'($urandom_range(0, 4095));
          end else begin
            px = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            py = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          end
          prev_x = px;
          prev_y = py;
          send_point(px, py, 16'($urandom_range(0, 65535)), k == scan_len - 1,
                     1'b0, UNTYPED);
        end
        sent += scan_len;
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the longest
  // gaps on the sending side and the longest stalls on the result side.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
design/npco_pkg.sv
design/npco_front.sv
design/npco_queue.sv
design/npco_back.sv
design/nearest_point_compass_octant.sv
verif/nearest_point_compass_octant_tb.sv
